### hdl/spt_pkg.sv
// Shared types, register codes and reset values for the stepped pulse train generator.
package spt_pkg;

   localparam int CNT_W  = 8;
   localparam int WID_W  = 16;
   localparam int TICK_W = 17;
   localparam int IDX_W  = 3;
   localparam int PH_W   = 3;

   // Sequencer phase codes
   localparam logic [PH_W-1:0] PH_IDLE = 3'd0;
   localparam logic [PH_W-1:0] PH_SYNC = 3'd1;
   localparam logic [PH_W-1:0] PH_HIGH = 3'd2;
   localparam logic [PH_W-1:0] PH_LOW  = 3'd3;
   localparam logic [PH_W-1:0] PH_GAP  = 3'd4;

   // Register indexes
   localparam logic [IDX_W-1:0] REG_BASE_WIDTH  = 3'd0;
   localparam logic [IDX_W-1:0] REG_LOW_GAP     = 3'd1;
   localparam logic [IDX_W-1:0] REG_PULSE_COUNT = 3'd2;
   localparam logic [IDX_W-1:0] REG_FRAME_GAP   = 3'd3;
   localparam logic [IDX_W-1:0] REG_WIDTH_STEP  = 3'd4;
   localparam logic [IDX_W-1:0] REG_MAX_EXTRA   = 3'd5;
   localparam logic [IDX_W-1:0] REG_SYNC_WIDTH  = 3'd6;

   // Register reset values
   localparam logic [WID_W-1:0] RST_BASE_WIDTH  = 16'd300;
   localparam logic [WID_W-1:0] RST_LOW_GAP     = 16'd100;
   localparam logic [CNT_W-1:0] RST_PULSE_COUNT = 8'd13;
   localparam logic [WID_W-1:0] RST_FRAME_GAP   = 16'd6500;
   localparam logic [WID_W-1:0] RST_WIDTH_STEP  = 16'd50;
   localparam logic [WID_W-1:0] RST_MAX_EXTRA   = 16'd650;
   localparam logic [WID_W-1:0] RST_SYNC_WIDTH  = 16'd500;

   typedef struct packed {
      logic [WID_W-1:0] base_width;
      logic [WID_W-1:0] low_gap;
      logic [CNT_W-1:0] pulse_count;
      logic [WID_W-1:0] frame_gap;
      logic [WID_W-1:0] width_step;
      logic [WID_W-1:0] max_extra;
      logic [WID_W-1:0] sync_width;
   } cfg_type;

   typedef struct packed {
      logic level_a;
      logic level_b;
      logic frame_end;
   } tick_result_type;

endpackage

### hdl/spt_req_if.sv
// Request channel: one tick carrying the two switch levels.
interface spt_req_if;
   logic valid;
   logic ready;
   logic stop_switch;
   logic invert_switch;

   modport source (output valid, output stop_switch, output invert_switch, input ready);
   modport sink   (input valid, input stop_switch, input invert_switch, output ready);
endinterface

### hdl/spt_rsp_if.sv
// Response channel: output levels and end-of-frame mark for one tick.
interface spt_rsp_if;
   logic valid;
   logic ready;
   logic level_a;
   logic level_b;
   logic frame_end;

   modport source (output valid, output level_a, output level_b, output frame_end,
                   input ready);
   modport sink   (input valid, input level_a, input level_b, input frame_end,
                   output ready);
endinterface

### hdl/spt_csr.sv
// Configuration register bank.
module spt_csr (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     write_enable,
   input  logic [spt_pkg::IDX_W-1:0] index,
   input  logic [spt_pkg::WID_W-1:0] write_data,
   output spt_pkg::cfg_type         cfg
);

   spt_pkg::cfg_type cfg_ff;
   spt_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_enable) begin
         case (index)
            spt_pkg::REG_BASE_WIDTH:  cfg_in.base_width  = write_data;
            spt_pkg::REG_LOW_GAP:     cfg_in.low_gap     = write_data;
            spt_pkg::REG_PULSE_COUNT: cfg_in.pulse_count = write_data[spt_pkg::CNT_W-1:0];
            spt_pkg::REG_FRAME_GAP:   cfg_in.frame_gap   = write_data;
            spt_pkg::REG_WIDTH_STEP:  cfg_in.width_step  = write_data;
            spt_pkg::REG_MAX_EXTRA:   cfg_in.max_extra   = write_data;
            spt_pkg::REG_SYNC_WIDTH:  cfg_in.sync_width  = write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_width  <= spt_pkg::RST_BASE_WIDTH;
         cfg_ff.low_gap     <= spt_pkg::RST_LOW_GAP;
         cfg_ff.pulse_count <= spt_pkg::RST_PULSE_COUNT;
         cfg_ff.frame_gap   <= spt_pkg::RST_FRAME_GAP;
         cfg_ff.width_step  <= spt_pkg::RST_WIDTH_STEP;
         cfg_ff.max_extra   <= spt_pkg::RST_MAX_EXTRA;
         cfg_ff.sync_width  <= spt_pkg::RST_SYNC_WIDTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/spt_sequencer.sv
// Frame sequencer: phase state, tick counter and per-pulse width stepping.
module spt_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  logic                     stop_switch,
   input  logic                     invert_switch,
   input  spt_pkg::cfg_type         cfg,
   output spt_pkg::tick_result_type result
);

   typedef struct packed {
      logic [spt_pkg::PH_W-1:0]   phase;
      logic [spt_pkg::TICK_W-1:0] ticks;
      logic [spt_pkg::CNT_W-1:0]  index;
      logic [spt_pkg::WID_W-1:0]  extra;
   } seq_type;

   logic [spt_pkg::PH_W-1:0]   phase_ff, phase_in;
   logic [spt_pkg::TICK_W-1:0] ticks_left_ff, ticks_left_in;
   logic [spt_pkg::CNT_W-1:0]  pulse_index_ff, pulse_index_in;
   logic [spt_pkg::WID_W-1:0]  pulse_extra_ff, pulse_extra_in;
   logic                       invert_mode_ff, invert_mode_in;

   // Extra width after one finished pulse
   function automatic logic [spt_pkg::WID_W-1:0] step_extra(
      input logic [spt_pkg::WID_W-1:0] ext, input logic inv, input spt_pkg::cfg_type c);
      logic [spt_pkg::WID_W:0] sum;
      sum = {1'b0, ext} + {1'b0, c.width_step};
      if (inv) begin
         step_extra = (ext > c.width_step) ? (ext - c.width_step) : '0;
      end else begin
         step_extra = sum[spt_pkg::WID_W] ? '1 : sum[spt_pkg::WID_W-1:0];
      end
   endfunction

   function automatic seq_type gap_entry(input seq_type s, input spt_pkg::cfg_type c);
      seq_type r;
      r = s;
      if (c.frame_gap != '0) begin
         r.phase = spt_pkg::PH_GAP;
         r.ticks = {1'b0, c.frame_gap};
      end else begin
         r.phase = spt_pkg::PH_IDLE;
         r.ticks = '0;
      end
      return r;
   endfunction

   // Load a pulse; a pulse of zero high and low time is skipped in closed form:
   // with zero extra it steps once given a nonzero normal-mode step, else all remaining skip
   function automatic seq_type high_entry(input logic [spt_pkg::CNT_W-1:0] idx,
      input logic [spt_pkg::WID_W-1:0] ext, input logic inv, input spt_pkg::cfg_type c);
      seq_type r;
      logic [spt_pkg::TICK_W-1:0] hw;
      logic [spt_pkg::WID_W-1:0]  e1;
      logic [spt_pkg::CNT_W-1:0]  idx1;
      r.index = idx;
      r.extra = ext;
      r.phase = spt_pkg::PH_HIGH;
      r.ticks = '0;
      hw = {1'b0, c.base_width} + {1'b0, ext};
      e1 = step_extra(ext, inv, c);
      idx1 = idx + 8'd1;
      if (hw != '0) begin
         r.ticks = hw;
      end else if (c.low_gap != '0) begin
         r.phase = spt_pkg::PH_LOW;
         r.ticks = {1'b0, c.low_gap};
      end else begin
         r.extra = e1;
         if (idx1 >= c.pulse_count || idx1 == '0) begin
            r.index = idx1;
            r = gap_entry(r, c);
         end else if (e1 != '0) begin
            r.index = idx1;
            r.ticks = {1'b0, e1};
         end else begin
            r.index = c.pulse_count;
            r = gap_entry(r, c);
         end
      end
      return r;
   endfunction

   function automatic seq_type decide(input logic [spt_pkg::CNT_W-1:0] idx,
      input logic [spt_pkg::WID_W-1:0] ext, input logic inv, input spt_pkg::cfg_type c);
      seq_type r;
      r.phase = spt_pkg::PH_IDLE;
      r.ticks = '0;
      r.index = idx;
      r.extra = ext;
      if (idx >= c.pulse_count) begin
         r = gap_entry(r, c);
      end else begin
         r = high_entry(idx, ext, inv, c);
      end
      return r;
   endfunction

   function automatic seq_type low_exit(input logic [spt_pkg::CNT_W-1:0] idx,
      input logic [spt_pkg::WID_W-1:0] ext, input logic inv, input spt_pkg::cfg_type c);
      seq_type r;
      logic [spt_pkg::WID_W-1:0] e;
      logic [spt_pkg::CNT_W-1:0] idx1;
      e = step_extra(ext, inv, c);
      idx1 = idx + 8'd1;
      r.phase = spt_pkg::PH_IDLE;
      r.ticks = '0;
      r.index = idx1;
      r.extra = e;
      if (idx1 >= c.pulse_count || idx1 == '0) begin
         r = gap_entry(r, c);
      end else begin
         r = high_entry(idx1, e, inv, c);
      end
      return r;
   endfunction

   // Leave the current phase for the next one of nonzero length
   function automatic seq_type advance(input seq_type s, input logic inv,
      input spt_pkg::cfg_type c);
      seq_type r;
      r = s;
      case (s.phase)
         spt_pkg::PH_IDLE: begin
            if (c.sync_width != '0) begin
               r.phase = spt_pkg::PH_SYNC;
               r.ticks = {1'b0, c.sync_width};
            end else begin
               r = decide(s.index, s.extra, inv, c);
            end
         end
         spt_pkg::PH_SYNC: r = decide(s.index, s.extra, inv, c);
         spt_pkg::PH_HIGH: begin
            if (c.low_gap != '0) begin
               r.phase = spt_pkg::PH_LOW;
               r.ticks = {1'b0, c.low_gap};
            end else begin
               r = low_exit(s.index, s.extra, inv, c);
            end
         end
         spt_pkg::PH_LOW: r = low_exit(s.index, s.extra, inv, c);
         default: begin
            r.phase = spt_pkg::PH_IDLE;
            r.ticks = '0;
         end
      endcase
      return r;
   endfunction

   seq_type cur, start, first, run, nxt, last;
   logic    run_valid;
   logic    inv_sel;
   logic [spt_pkg::TICK_W-1:0] dec;

   always_comb begin
      cur  = '{phase: phase_ff, ticks: ticks_left_ff, index: pulse_index_ff,
               extra: pulse_extra_ff};
      nxt       = cur;
      inv_sel   = invert_mode_ff;
      run       = cur;
      run_valid = 1'b0;
      result    = '0;
      start.phase = spt_pkg::PH_IDLE;
      start.ticks = '0;
      start.index = '0;
      start.extra = invert_switch ? cfg.max_extra : '0;
      first = advance(start, invert_switch, cfg);
      if (phase_ff == spt_pkg::PH_IDLE) begin
         if (!stop_switch) begin
            inv_sel = invert_switch;
            if (first.phase == spt_pkg::PH_IDLE) begin
               nxt = first;
               result.frame_end = 1'b1;
            end else begin
               run = first;
               run_valid = 1'b1;
            end
         end
      end else begin
         run_valid = 1'b1;
      end
      dec = run.ticks - 17'd1;
      last = run;
      last.ticks = '0;
      last = advance(last, inv_sel, cfg);
      if (run_valid) begin
         result.level_a = (run.phase == spt_pkg::PH_HIGH);
         result.level_b = (run.phase == spt_pkg::PH_SYNC);
         if (dec == '0) begin
            nxt = last;
            result.frame_end = (last.phase == spt_pkg::PH_IDLE);
         end else begin
            nxt = run;
            nxt.ticks = dec;
         end
      end
      phase_in       = nxt.phase;
      ticks_left_in  = nxt.ticks;
      pulse_index_in = nxt.index;
      pulse_extra_in = nxt.extra;
      invert_mode_in = inv_sel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= spt_pkg::PH_IDLE;
         ticks_left_ff  <= '0;
         pulse_index_ff <= '0;
         pulse_extra_ff <= '0;
         invert_mode_ff <= 1'b0;
      end else if (fire) begin
         phase_ff       <= phase_in;
         ticks_left_ff  <= ticks_left_in;
         pulse_index_ff <= pulse_index_in;
         pulse_extra_ff <= pulse_extra_in;
         invert_mode_ff <= invert_mode_in;
      end
   end

   a_running_has_ticks: assert property (@(posedge clock) disable iff (reset)
      phase_ff != spt_pkg::PH_IDLE |-> ticks_left_ff != '0)
      else $error("running phase with zero ticks left");

   a_idle_no_ticks: assert property (@(posedge clock) disable iff (reset)
      phase_ff == spt_pkg::PH_IDLE |-> ticks_left_ff == '0)
      else $error("idle phase holds a tick count");

   a_end_to_idle: assert property (@(posedge clock) disable iff (reset)
      fire && result.frame_end |=> phase_ff == spt_pkg::PH_IDLE)
      else $error("frame end not followed by idle");

   a_outputs_exclusive: assert property (@(posedge clock) disable iff (reset)
      fire |-> !(result.level_a && result.level_b))
      else $error("A and B high on the same tick");

endmodule

### hdl/stepped_pulse_train_generator.sv
// Stepped pulse train generator: sync pulse on B, then a train of stepped-width pulses on A.
// Path: an accepted request is held in the request register, and its result goes into the
// response register around the sequencer update.
// Throughput: one request per cycle while the response slot is free or being taken; the
// sequencer steps its tick counter and loads the next phase, skipping zero-length ones,
// in the same cycle.
// Reset (synchronous, active high): registers return to their defaults, phase goes idle,
// and both channel stages empty.
module stepped_pulse_train_generator (
   input  logic                      clock,
   input  logic                      reset,
   spt_req_if.sink                   req_ch,
   spt_rsp_if.source                 rsp_ch,
   input  logic                      csr_write_enable,
   input  logic [spt_pkg::IDX_W-1:0] csr_index,
   input  logic [spt_pkg::WID_W-1:0] csr_write_data
);

   spt_pkg::cfg_type         cfg;
   spt_pkg::tick_result_type tick_result;

   // Request stage
   logic in_valid_ff, in_valid_in;
   logic in_stop_ff, in_stop_in;
   logic in_invert_ff, in_invert_in;

   // Response stage
   logic                     out_valid_ff, out_valid_in;
   spt_pkg::tick_result_type out_result_ff, out_result_in;

   logic pipe_move;
   logic fire;

   spt_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .write_enable (csr_write_enable),
      .index        (csr_index),
      .write_data   (csr_write_data),
      .cfg          (cfg)
   );

   // Advance the pipe whenever the response slot is empty or being taken
   assign pipe_move    = !out_valid_ff || rsp_ch.ready;
   assign fire         = in_valid_ff && pipe_move;
   assign req_ch.ready = !in_valid_ff || pipe_move;

   spt_sequencer u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .stop_switch   (in_stop_ff),
      .invert_switch (in_invert_ff),
      .cfg           (cfg),
      .result        (tick_result)
   );

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_stop_in    = in_stop_ff;
      in_invert_in  = in_invert_ff;
      out_valid_in  = out_valid_ff;
      out_result_in = out_result_ff;
      // Take a new request when the stage is free or drains this cycle
      if (req_ch.ready) begin
         in_valid_in  = req_ch.valid;
         in_stop_in   = req_ch.stop_switch;
         in_invert_in = req_ch.invert_switch;
      end
      // Load the response slot from the sequencer, or drop it once taken
      if (pipe_move) begin
         out_valid_in = in_valid_ff;
         if (fire) begin
            out_result_in = tick_result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload holds no reset
   always_ff @(posedge clock) begin
      in_stop_ff    <= in_stop_in;
      in_invert_ff  <= in_invert_in;
      out_result_ff <= out_result_in;
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.level_a   = out_result_ff.level_a;
   assign rsp_ch.level_b   = out_result_ff.level_b;
   assign rsp_ch.frame_end = out_result_ff.frame_end;

endmodule
